FILE: sv/battery_supervisor_macros.svh
// Assertion macros shared by the battery supervisor modules.
`ifndef BATTERY_SUPERVISOR_MACROS_SVH
`define BATTERY_SUPERVISOR_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BSUP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BSUP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bsup_pkg.sv
// Types, register codes and constants of the battery supervisor.
`default_nettype none

package bsup_pkg;

	localparam int WINDOW_LEN_DEFAULT = 50;
	localparam int WINDOW_LEN_MAX     = 256;

	localparam int VOLTS_W  = 8;
	localparam int AMPS_W   = 9;
	localparam int MS_W     = 16;
	localparam int TIME_W   = 32;
	localparam int CUR_W    = 16;
	localparam int MAG_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int AMPS_FIELD_MAX = (2 ** AMPS_W) - 1;
	localparam int CENTI_PER_AMP  = 100;
	localparam int LIMIT_W = $clog2(AMPS_FIELD_MAX * CENTI_PER_AMP * WINDOW_LEN_MAX + 1);

	localparam logic [VOLTS_W-1:0] MIN_VOLTS_RESET      = 8'd30;
	localparam logic [VOLTS_W-1:0] MAX_VOLTS_RESET      = 8'd60;
	localparam logic [VOLTS_W-1:0] LOW_WARN_VOLTS_RESET = 8'd36;
	localparam int                 AMPS_RESET           = 30;
	localparam logic [MS_W-1:0]    CHECK_PERIOD_RESET   = 16'd300;
	localparam logic [MS_W-1:0]    WARN_INTERVAL_RESET  = 16'd5000;

	localparam logic [VOLTS_W-1:0] VOLTS_INVALID_MAX = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_VOLTS      = 3'd0,
		REG_MAX_VOLTS      = 3'd1,
		REG_LOW_WARN_VOLTS = 3'd2,
		REG_MAX_AVG_AMPS   = 3'd3,
		REG_CHECK_PERIOD   = 3'd4,
		REG_WARN_INTERVAL  = 3'd5
	} bsup_reg_t;

	typedef struct packed {
		logic [VOLTS_W-1:0] min_volts;
		logic [VOLTS_W-1:0] max_volts;
		logic [VOLTS_W-1:0] low_warn_volts;
		logic [LIMIT_W-1:0] avg_limit;
		logic [MS_W-1:0]    check_period;
		logic [MS_W-1:0]    warn_interval;
	} bsup_cfg_t;

endpackage

`default_nettype wire

FILE: sv/bsup_cfg.sv
// Configuration registers, including the precomputed window sum limit.
`default_nettype none

module bsup_cfg
	import bsup_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output bsup_cfg_t                  cfg
);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET =
		LIMIT_W'(AMPS_RESET * CENTI_PER_AMP * WINDOW_LEN);

	bsup_cfg_t cfg_q;

	logic [LIMIT_W-1:0] limit_wr;

	// The limit is amps times 100 times the window length, kept in centiamps.
	assign limit_wr = LIMIT_W'(32'(wr_data[AMPS_W-1:0]) * 32'(CENTI_PER_AMP * WINDOW_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_volts      <= MIN_VOLTS_RESET;
			cfg_q.max_volts      <= MAX_VOLTS_RESET;
			cfg_q.low_warn_volts <= LOW_WARN_VOLTS_RESET;
			cfg_q.avg_limit      <= LIMIT_RESET;
			cfg_q.check_period   <= CHECK_PERIOD_RESET;
			cfg_q.warn_interval  <= WARN_INTERVAL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MIN_VOLTS:      cfg_q.min_volts      <= wr_data[VOLTS_W-1:0];
				REG_MAX_VOLTS:      cfg_q.max_volts      <= wr_data[VOLTS_W-1:0];
				REG_LOW_WARN_VOLTS: cfg_q.low_warn_volts <= wr_data[VOLTS_W-1:0];
				REG_MAX_AVG_AMPS:   cfg_q.avg_limit      <= limit_wr;
				REG_CHECK_PERIOD:   cfg_q.check_period   <= wr_data[MS_W-1:0];
				REG_WARN_INTERVAL:  cfg_q.warn_interval  <= wr_data[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/bsup_window.sv
// Current magnitude window memory with running sum and prefetched oldest entry.
`default_nettype none
`include "battery_supervisor_macros.svh"

module bsup_window
	import bsup_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT,
	parameter int SUM_W      = $clog2(WINDOW_LEN * (2 ** (MAG_W - 1)) + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [MAG_W-1:0] magnitude,
	output logic      [SUM_W-1:0] sum_next
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

	logic [MAG_W-1:0]      mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] vld_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     slot_nxt;
	logic [MAG_W-1:0]      rd_q;
	logic                  rdv_q;
	logic [SUM_W-1:0]      sum_q;
	logic [MAG_W-1:0]      oldest;

	assign slot_nxt = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

	// The entry at slot_q is always waiting in rd_q; an entry never written reads as zero.
	assign oldest   = rdv_q ? rd_q : '0;
	assign sum_next = sum_q - SUM_W'(oldest) + SUM_W'(magnitude);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[slot_q] <= magnitude;
			rd_q        <= mem[slot_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			slot_q <= '0;
			rdv_q  <= 1'b0;
			sum_q  <= '0;
		end else if (push) begin
			vld_q[slot_q] <= 1'b1;
			slot_q        <= slot_nxt;
			rdv_q         <= vld_q[slot_nxt];
			sum_q         <= sum_next;
		end
	end

	`BSUP_ASSERT_IMPLIES(a_slot_range, 1'b1, slot_q <= SLOT_LAST, "window slot out of range")
	`BSUP_ASSERT_NEXT(a_sum_hold, !push, $stable(sum_q), "window sum changed without a push")
	`BSUP_ASSERT_NEXT(a_slot_moves, push, !$stable(slot_q), "window slot did not advance")

endmodule

`default_nettype wire

FILE: sv/battery_supervisor.sv
// Top level of the battery supervisor: input register, checks and result register.
//
//  channel   direction  handshake                payload
//  sample    in         sample_valid/stall       now_ms, battery_volts, current_centiamps
//  result    out        result_valid/stall       sample_used, range_alarm, two warnings
//  cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// Each sample passes from acceptance into the input register, then through the checks
// into the result register. A new sample is accepted every cycle while sample_stall is low.
// The window sum and the oldest window entry, prefetched from the window memory, are
// ready each cycle, so the rate is one sample per cycle while the result is not stalled.
// Reset restores the register defaults and an all-zero window; no clearing pass is needed.
// A stalled result holds the input register, and sample_stall rises only when both are full.
`default_nettype none
`include "battery_supervisor_macros.svh"

module battery_supervisor
	import bsup_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    sample_valid,
	output logic                         sample_stall,
	input  wire logic [TIME_W-1:0]       now_ms,
	input  wire logic [VOLTS_W-1:0]      battery_volts,
	input  wire logic signed [CUR_W-1:0] current_centiamps,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic                         sample_used,
	output logic                         range_alarm,
	output logic                         low_voltage_warning,
	output logic                         high_current_warning,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int SUM_W = $clog2(WINDOW_LEN * (2 ** (MAG_W - 1)) + 1);
	localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

	bsup_cfg_t cfg;

	logic                    valid_s1;
	logic [TIME_W-1:0]       now_s1;
	logic [VOLTS_W-1:0]      volts_s1;
	logic signed [CUR_W-1:0] cur_s1;

	logic [TIME_W-1:0] last_check_q;
	logic [TIME_W-1:0] last_vwarn_q;
	logic [TIME_W-1:0] last_cwarn_q;

	logic              adv;
	logic              proc;
	logic              used;
	logic              push;
	logic [TIME_W-1:0] since_check;
	logic [TIME_W-1:0] since_vwarn;
	logic [TIME_W-1:0] since_cwarn;
	logic [MAG_W-1:0]  magnitude;
	logic [SUM_W-1:0]  sum_next;
	logic              volts_ok;
	logic              alarm;
	logic              in_window;
	logic              vwarn;
	logic              cwarn;

	bsup_cfg #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	bsup_window #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W     (SUM_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.magnitude(magnitude),
		.sum_next (sum_next)
	);

	assign cfg_ready = 1'b1;

	assign adv          = !result_valid || !result_stall;
	assign sample_stall = valid_s1 && !adv;
	assign proc         = valid_s1 && adv;

	assign since_check = now_s1 - last_check_q;
	assign since_vwarn = now_s1 - last_vwarn_q;
	assign since_cwarn = now_s1 - last_cwarn_q;

	assign used = since_check >= TIME_W'(cfg.check_period);
	assign push = proc && used;

	// The most negative current negates to 0x8000, which is its magnitude when read unsigned.
	assign magnitude = cur_s1[CUR_W-1] ? $unsigned(-cur_s1) : $unsigned(cur_s1);

	assign volts_ok  = volts_s1 > VOLTS_INVALID_MAX;
	assign alarm     = volts_ok && (volts_s1 < cfg.min_volts || volts_s1 > cfg.max_volts);
	assign in_window = volts_ok && !alarm;

	assign vwarn = used && in_window && volts_s1 < cfg.low_warn_volts
		&& since_vwarn > TIME_W'(cfg.warn_interval);
	assign cwarn = used && in_window && CMP_W'(sum_next) > CMP_W'(cfg.avg_limit)
		&& since_cwarn > TIME_W'(cfg.warn_interval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			now_s1   <= now_ms;
			volts_s1 <= battery_volts;
			cur_s1   <= current_centiamps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_check_q <= '0;
			last_vwarn_q <= '0;
			last_cwarn_q <= '0;
		end else if (push) begin
			last_check_q <= now_s1;
			if (vwarn) begin
				last_vwarn_q <= now_s1;
			end
			if (cwarn) begin
				last_cwarn_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			sample_used          <= used;
			range_alarm          <= used && alarm;
			low_voltage_warning  <= vwarn;
			high_current_warning <= cwarn;
		end
	end

	`BSUP_ASSERT_IMPLIES(a_alarm_excl, result_valid && range_alarm, !low_voltage_warning && !high_current_warning, "warning given with range alarm")
	`BSUP_ASSERT_IMPLIES(a_flags_used, result_valid && !sample_used, !range_alarm && !low_voltage_warning && !high_current_warning, "flag set on an unused sample")
	`BSUP_ASSERT_NEXT(a_check_hold, !push, $stable(last_check_q), "check time moved without a used sample")

endmodule

`default_nettype wire
